>>> rtl/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared widths, coefficient reset values, control-word layout and the
// microcode program of the biquad filter core.
// ----------------------------------------------------------------------------
package bqd_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W = 17;
  localparam int COEF_W   = 32;
  localparam int MUL_W    = 32;
  localparam int COEF_N   = 5;

  // Output saturation limits, as magnitudes and as sample codes
  localparam int OUT_POS_LIM = 65535;
  localparam int OUT_NEG_LIM = 65536;
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 17'sh0FFFF;
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 17'sh10000;

  // Item commands
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Coefficient register indexes
  typedef logic [2:0] coef_idx_t;
  localparam coef_idx_t COEF_B0 = 3'd0;
  localparam coef_idx_t COEF_B1 = 3'd1;
  localparam coef_idx_t COEF_B2 = 3'd2;
  localparam coef_idx_t COEF_A1 = 3'd3;
  localparam coef_idx_t COEF_A2 = 3'd4;

  localparam logic signed [COEF_W-1:0] COEF_RESET [COEF_N] = '{
    32'sd5390989, 32'sd10782247, 32'sd5390989, -32'sd419032579, 32'sd172161617
  };

  // Program counter
  typedef logic [3:0] step_t;
  localparam step_t STEP_FETCH = 4'd0;
  localparam step_t STEP_CLEAR = 4'd13;

  // Wait conditions: the step holds, with no side effects, until met
  typedef logic [1:0] wait_t;
  localparam wait_t WAIT_NONE = 2'd0;
  localparam wait_t WAIT_ITEM = 2'd1;
  localparam wait_t WAIT_OUT  = 2'd2;

  // Jump conditions
  typedef logic [1:0] jmp_t;
  localparam jmp_t JMP_NEXT   = 2'd0;
  localparam jmp_t JMP_ALWAYS = 2'd1;
  localparam jmp_t JMP_CLEAR  = 2'd2;

  // Multiplier operand select
  typedef logic [1:0] opnd_t;
  localparam opnd_t OPND_X      = 2'd0;
  localparam opnd_t OPND_ACC_LO = 2'd1;
  localparam opnd_t OPND_ACC_HI = 2'd2;

  // Product accumulator ops
  typedef logic [1:0] pacc_op_t;
  localparam pacc_op_t PACC_NOP   = 2'd0;
  localparam pacc_op_t PACC_LOAD  = 2'd1;
  localparam pacc_op_t PACC_ADDHI = 2'd2;

  // Term conversion ops
  typedef logic [1:0] term_op_t;
  localparam term_op_t TERM_NOP      = 2'd0;
  localparam term_op_t TERM_INT      = 2'd1;
  localparam term_op_t TERM_FRAC_NEG = 2'd2;

  // State ALU ops
  typedef logic [2:0] alu_op_t;
  localparam alu_op_t ALU_NOP       = 3'd0;
  localparam alu_op_t ALU_ADD_ACC   = 3'd1;
  localparam alu_op_t ALU_LD_D1     = 3'd2;
  localparam alu_op_t ALU_ADD_D1    = 3'd3;
  localparam alu_op_t ALU_ADD_D1_D2 = 3'd4;
  localparam alu_op_t ALU_LD_D2     = 3'd5;
  localparam alu_op_t ALU_ADD_D2    = 3'd6;
  localparam alu_op_t ALU_CLEAR     = 3'd7;

  // One control word per step
  typedef struct packed {
    wait_t     wait_sel;
    jmp_t      jmp_sel;
    step_t     jmp_tgt;
    logic      mul_en;
    coef_idx_t mul_csel;
    opnd_t     mul_osel;
    pacc_op_t  pacc_op;
    term_op_t  term_op;
    alu_op_t   alu_op;
    logic      out_load;
  } cw_t;

  // Status fed back to the sequencer
  typedef struct packed {
    logic item_valid;
    logic out_free;
    logic clear_cmd;
  } stat_t;

  localparam cw_t CW_NOP = '{
    wait_sel: WAIT_NONE, jmp_sel: JMP_NEXT, jmp_tgt: STEP_FETCH,
    mul_en: 1'b0, mul_csel: COEF_B0, mul_osel: OPND_X,
    pacc_op: PACC_NOP, term_op: TERM_NOP, alu_op: ALU_NOP, out_load: 1'b0
  };

  // Microcode ROM. Multiply, accumulate, convert and add run as four
  // overlapped stages; each field acts on what the stage before left.
  function automatic cw_t bqd_ucode(input step_t pc);
    cw_t cw;
    cw = CW_NOP;
    case (pc)
      // wait for an item
      4'd0: begin
        cw.wait_sel = WAIT_ITEM;
      end
      // b0*x, branch off on a clear command
      4'd1: begin
        cw.mul_en = 1'b1; cw.mul_csel = COEF_B0; cw.mul_osel = OPND_X;
        cw.jmp_sel = JMP_CLEAR; cw.jmp_tgt = STEP_CLEAR;
      end
      4'd2: begin
        cw.pacc_op = PACC_LOAD;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_B1; cw.mul_osel = OPND_X;
      end
      4'd3: begin
        cw.term_op = TERM_INT; cw.pacc_op = PACC_LOAD;
      end
      // acc = b0*x + d1
      4'd4: begin
        cw.alu_op = ALU_ADD_ACC; cw.term_op = TERM_INT;
      end
      // d1 = b1*x, start a1*acc
      4'd5: begin
        cw.alu_op = ALU_LD_D1;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_A1; cw.mul_osel = OPND_ACC_LO;
      end
      4'd6: begin
        cw.pacc_op = PACC_LOAD;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_A1; cw.mul_osel = OPND_ACC_HI;
      end
      4'd7: begin
        cw.pacc_op = PACC_ADDHI;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_A2; cw.mul_osel = OPND_ACC_LO;
      end
      4'd8: begin
        cw.term_op = TERM_FRAC_NEG; cw.pacc_op = PACC_LOAD;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_A2; cw.mul_osel = OPND_ACC_HI;
      end
      // d1 += -a1*acc
      4'd9: begin
        cw.alu_op = ALU_ADD_D1; cw.pacc_op = PACC_ADDHI;
        cw.mul_en = 1'b1; cw.mul_csel = COEF_B2; cw.mul_osel = OPND_X;
      end
      // d1 += d2
      4'd10: begin
        cw.alu_op = ALU_ADD_D1_D2; cw.term_op = TERM_FRAC_NEG; cw.pacc_op = PACC_LOAD;
      end
      // d2 = -a2*acc
      4'd11: begin
        cw.alu_op = ALU_LD_D2; cw.term_op = TERM_INT;
      end
      // d2 += b2*x, hand the result over once the output register is free
      4'd12: begin
        cw.alu_op = ALU_ADD_D2; cw.out_load = 1'b1; cw.wait_sel = WAIT_OUT;
        cw.jmp_sel = JMP_ALWAYS; cw.jmp_tgt = STEP_FETCH;
      end
      // clear command
      4'd13: begin
        cw.alu_op = ALU_CLEAR;
        cw.jmp_sel = JMP_ALWAYS; cw.jmp_tgt = STEP_FETCH;
      end
      default: begin
        cw.jmp_sel = JMP_ALWAYS; cw.jmp_tgt = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/biquad_iir_df2t_filter_core.sv
// ----------------------------------------------------------------------------
// biquad_iir_df2t_filter_core
// Second-order IIR section, direct form II transposed, fixed point, run by a
// microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_ready  | in_cmd, in_sample_in
//  out     | output    | out_valid/out_ready| out_sample_out
//  cfg     | input     | cfg_we             | cfg_idx, cfg_data
//
//  A filter item runs through the whole program before the next item can be
//  taken: seven 32x32 products (two per coefficient times acc) pass one at a
//  time through the shared multiplier. A clear item skips to the clear step.
//  The result is written to the output register; the next item is accepted
//  while it waits. If the output register is still full at the final step,
//  the sequencer holds there until it drains.
//  Reset (synchronous, active low) loads the default coefficients and zeroes
//  both delays.
//
module biquad_iir_df2t_filter_core #(
  parameter int COEF_FRAC_BITS = 28,
  parameter int STATE_WIDTH    = 56
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [bqd_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bqd_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_we,
  input  bqd_pkg::coef_idx_t                  cfg_idx,
  input  logic        [bqd_pkg::COEF_W-1:0]   cfg_data
);

  bqd_pkg::cw_t                        cw;
  bqd_pkg::stat_t                      stat;
  logic                                go;
  logic                                out_free;
  logic                                clear_cmd;
  logic                                out_load;
  logic signed [bqd_pkg::SAMPLE_W-1:0] y_val;
  logic                                out_valid_r;
  logic signed [bqd_pkg::SAMPLE_W-1:0] out_sample_out_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (cw.wait_sel == bqd_pkg::WAIT_ITEM);
  assign out_load = cw.out_load && go;

  assign stat = '{item_valid: in_valid, out_free: out_free, clear_cmd: clear_cmd};

  bqd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw),
    .go    (go)
  );

  bqd_dp #(
    .FRAC_W (COEF_FRAC_BITS),
    .SW     (STATE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cw           (cw),
    .go           (go),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_cmd       (in_cmd),
    .in_sample_in (in_sample_in),
    .clear_cmd    (clear_cmd),
    .y_val        (y_val)
  );

  // Output register: load the result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_out_r <= y_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_out_r;

  // One item in flight: the sequencer leaves the fetch step after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted in the cycle after an accept");

  // A result is only written into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwrote a pending output");

  // The sequencer only stalls on a wait step
  a_stall_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !go |-> (cw.wait_sel == bqd_pkg::WAIT_ITEM || cw.wait_sel == bqd_pkg::WAIT_OUT))
    else $error("sequencer stalled on a step without a wait");

  // A clear item produces no result
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == bqd_pkg::CMD_CLEAR)) |=> !cw.out_load ##1 !cw.out_load)
    else $error("clear item reached the output step");

endmodule

>>> rtl/bqd_seq.sv
// ----------------------------------------------------------------------------
// bqd_seq
// Microcode sequencer: step counter, ROM lookup, wait and jump handling.
// ----------------------------------------------------------------------------
module bqd_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  bqd_pkg::stat_t stat,
  output bqd_pkg::cw_t   cw,
  output logic           go
);

  bqd_pkg::step_t pc_r;
  bqd_pkg::step_t pc_nxt;
  logic           jmp_take;

  // Fetch the control word
  assign cw = bqd_pkg::bqd_ucode(pc_r);

  // Resolve the wait condition
  always_comb begin
    case (cw.wait_sel)
      bqd_pkg::WAIT_NONE: go = 1'b1;
      bqd_pkg::WAIT_ITEM: go = stat.item_valid;
      bqd_pkg::WAIT_OUT:  go = stat.out_free;
      default:            go = 1'b1;
    endcase
  end

  // Resolve the jump condition
  always_comb begin
    case (cw.jmp_sel)
      bqd_pkg::JMP_NEXT:   jmp_take = 1'b0;
      bqd_pkg::JMP_ALWAYS: jmp_take = 1'b1;
      bqd_pkg::JMP_CLEAR:  jmp_take = stat.clear_cmd;
      default:             jmp_take = 1'b0;
    endcase
  end

  // Hold while waiting, else jump or advance
  always_comb begin
    if (!go) begin
      pc_nxt = pc_r;
    end else if (jmp_take) begin
      pc_nxt = cw.jmp_tgt;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bqd_pkg::STEP_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/bqd_dp.sv
// ----------------------------------------------------------------------------
// bqd_dp
// Filter datapath: coefficient registers, shared 32x32 magnitude multiplier,
// product accumulator, term saturation, saturating state ALU and output
// truncation. Updates, bar coefficient writes and their delay clear, need go.
// ----------------------------------------------------------------------------
module bqd_dp #(
  parameter int FRAC_W = 28,
  parameter int SW     = 56
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bqd_pkg::cw_t                            cw,
  input  logic                                    go,
  input  logic                                    cfg_we,
  input  bqd_pkg::coef_idx_t                      cfg_idx,
  input  logic        [bqd_pkg::COEF_W-1:0]       cfg_data,
  input  logic                                    in_cmd,
  input  logic signed [bqd_pkg::SAMPLE_W-1:0]     in_sample_in,
  output logic                                    clear_cmd,
  output logic signed [bqd_pkg::SAMPLE_W-1:0]     y_val
);

  localparam int MW     = bqd_pkg::MUL_W;
  localparam int OPW    = 2 * MW;
  localparam int PACC_W = MW + OPW;
  localparam int QW     = OPW - FRAC_W;
  localparam int XW     = bqd_pkg::SAMPLE_W;

  localparam logic signed [SW-1:0]   S_MAX      = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]   S_MIN      = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0]   S_NEG_MAX  = {1'b1, {(SW-2){1'b0}}, 1'b1};
  localparam logic [PACC_W-1:0]      STATE_HALF = PACC_W'(1) << (SW - 1);
  localparam logic [QW-1:0]          Q_POS_LIM  = QW'(bqd_pkg::OUT_POS_LIM);
  localparam logic [QW-1:0]          Q_NEG_LIM  = QW'(bqd_pkg::OUT_NEG_LIM);

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? S_MIN : S_MAX;
    end
    return s[SW-1:0];
  endfunction

  logic signed [bqd_pkg::COEF_W-1:0] coef_r [bqd_pkg::COEF_N];
  logic signed [XW-1:0]              x_r;
  logic                              cmd_r;
  logic signed [SW-1:0]              acc_r, acc_nxt;
  logic signed [SW-1:0]              d1_r, d1_nxt;
  logic signed [SW-1:0]              d2_r, d2_nxt;
  logic        [OPW-1:0]             prod_r;
  logic                              psign_r;
  logic        [PACC_W-1:0]          pacc_r;
  logic                              pacc_sign_r;
  logic signed [SW-1:0]              term_r, term_val;

  logic                              take;
  logic                              cfg_hit;
  logic signed [bqd_pkg::COEF_W-1:0] coef_sel;
  logic                              c_neg;
  logic        [MW-1:0]              c_mag;
  logic                              x_neg;
  logic        [XW-1:0]              x_mag;
  logic                              acc_neg;
  logic signed [OPW-1:0]             acc_ext;
  logic        [OPW-1:0]             acc_mag;
  logic        [MW-1:0]              op_mag;
  logic                              op_neg;
  logic        [OPW-1:0]             mul_full;
  logic        [PACC_W-1:0]          mag_sel;
  logic                              t_neg;
  logic        [QW-1:0]              q;

  assign take      = go && (cw.wait_sel == bqd_pkg::WAIT_ITEM);
  assign cfg_hit   = cfg_we && (cfg_idx <= bqd_pkg::COEF_A2);
  assign clear_cmd = (cmd_r == bqd_pkg::CMD_CLEAR);

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bqd_pkg::COEF_N; i++) begin
        coef_r[i] <= bqd_pkg::COEF_RESET[i];
      end
    end else if (cfg_hit) begin
      coef_r[cfg_idx] <= cfg_data;
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (take) begin
      x_r   <= in_sample_in;
      cmd_r <= in_cmd;
    end
  end

  // Operand magnitudes and signs
  always_comb begin
    coef_sel = coef_r[cw.mul_csel];
    c_neg    = coef_sel[bqd_pkg::COEF_W-1];
    c_mag    = c_neg ? (~coef_sel + 1'b1) : coef_sel;
    x_neg    = x_r[XW-1];
    x_mag    = x_neg ? (~x_r + 1'b1) : x_r;
    acc_neg  = acc_r[SW-1];
    acc_ext  = OPW'(acc_r);
    acc_mag  = acc_neg ? (~acc_ext + 1'b1) : acc_ext;
    case (cw.mul_osel)
      bqd_pkg::OPND_X: begin
        op_mag = MW'(x_mag);
        op_neg = x_neg;
      end
      bqd_pkg::OPND_ACC_LO: begin
        op_mag = acc_mag[MW-1:0];
        op_neg = acc_neg;
      end
      bqd_pkg::OPND_ACC_HI: begin
        op_mag = acc_mag[OPW-1:MW];
        op_neg = acc_neg;
      end
      default: begin
        op_mag = '0;
        op_neg = 1'b0;
      end
    endcase
  end

  // Shared multiplier, registered
  assign mul_full = {{MW{1'b0}}, c_mag} * {{MW{1'b0}}, op_mag};

  always_ff @(posedge clk) begin
    if (go && cw.mul_en) begin
      prod_r  <= mul_full;
      psign_r <= c_neg ^ op_neg;
    end
  end

  // Product accumulator: low half loads, high half adds one word up
  always_ff @(posedge clk) begin
    if (go) begin
      case (cw.pacc_op)
        bqd_pkg::PACC_LOAD: begin
          pacc_r      <= PACC_W'(prod_r);
          pacc_sign_r <= psign_r;
        end
        bqd_pkg::PACC_ADDHI: begin
          pacc_r <= pacc_r + {prod_r, {MW{1'b0}}};
        end
        default: begin
          pacc_r <= pacc_r;
        end
      endcase
    end
  end

  // Scale, apply sign and saturate to the state range; a negated positive
  // fraction product clamps at minus the state maximum
  always_comb begin
    mag_sel = (cw.term_op == bqd_pkg::TERM_FRAC_NEG) ? (pacc_r >> FRAC_W) : pacc_r;
    t_neg   = pacc_sign_r ^ (cw.term_op == bqd_pkg::TERM_FRAC_NEG);
    if (t_neg) begin
      if ((cw.term_op == bqd_pkg::TERM_FRAC_NEG) && (mag_sel >= STATE_HALF)) begin
        term_val = S_NEG_MAX;
      end else if (mag_sel > STATE_HALF) begin
        term_val = S_MIN;
      end else begin
        term_val = ~mag_sel[SW-1:0] + 1'b1;
      end
    end else begin
      if (mag_sel >= STATE_HALF) begin
        term_val = S_MAX;
      end else begin
        term_val = mag_sel[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && (cw.term_op != bqd_pkg::TERM_NOP)) begin
      term_r <= term_val;
    end
  end

  // Saturating state ALU; a coefficient write clears both delays
  always_comb begin
    acc_nxt = acc_r;
    d1_nxt  = d1_r;
    d2_nxt  = d2_r;
    if (go) begin
      case (cw.alu_op)
        bqd_pkg::ALU_ADD_ACC:   acc_nxt = sat_add(term_r, d1_r);
        bqd_pkg::ALU_LD_D1:     d1_nxt  = term_r;
        bqd_pkg::ALU_ADD_D1:    d1_nxt  = sat_add(d1_r, term_r);
        bqd_pkg::ALU_ADD_D1_D2: d1_nxt  = sat_add(d1_r, d2_r);
        bqd_pkg::ALU_LD_D2:     d2_nxt  = term_r;
        bqd_pkg::ALU_ADD_D2:    d2_nxt  = sat_add(d2_r, term_r);
        bqd_pkg::ALU_CLEAR: begin
          d1_nxt = '0;
          d2_nxt = '0;
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
    if (cfg_hit) begin
      d1_nxt = '0;
      d2_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  // Truncate acc toward zero and saturate to the sample range
  always_comb begin
    q = acc_mag[OPW-1:FRAC_W];
    if (acc_neg) begin
      if (q > Q_NEG_LIM) begin
        y_val = bqd_pkg::OUT_MIN;
      end else begin
        y_val = ~q[XW-1:0] + 1'b1;
      end
    end else begin
      if (q > Q_POS_LIM) begin
        y_val = bqd_pkg::OUT_MAX;
      end else begin
        y_val = q[XW-1:0];
      end
    end
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the biquad filter core. A bit-exact fixed-point
// model of the DF2T section predicts each output sample; random gaps on the
// input side and back-pressure on the output side vary the timing, and
// coefficient sets change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int     FRAC_W         = 28;
  localparam int     STATE_W        = 56;
  localparam longint STATE_MAX      = (64'sd1 <<< (STATE_W - 1)) - 64'sd1;
  localparam longint STATE_MIN      = -STATE_MAX - 64'sd1;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     SETTLE_CYCLES  = 20;
  localparam int     PHASE_ITEMS    = 50;
  localparam int     RANDOM_PHASES  = 8;

  // Bit-exact tracker of the filter state and of the output samples still due
  class biquad_scoreboard;
    logic signed [bqd_pkg::COEF_W-1:0]   coef_q [bqd_pkg::COEF_N];
    longint                              delay_one;
    longint                              delay_two;
    logic signed [bqd_pkg::SAMPLE_W-1:0] pending_out [$];
    int                                  errors;

    function new();
      foreach (coef_q[i]) coef_q[i] = bqd_pkg::COEF_RESET[i];
      delay_one = 0;
      delay_two = 0;
      errors    = 0;
    endfunction

    function logic [63:0] mag_of(longint v);
      if (v < 0) return 64'(-v);
      return 64'(v);
    endfunction

    // Rebuild a signed state value from sign and magnitude, clamped
    function longint from_mag(bit neg, logic [127:0] mag);
      if (neg) begin
        if (mag > 128'(STATE_MAX) + 128'd1) return STATE_MIN;
        return -longint'(mag[63:0]);
      end
      if (mag > 128'(STATE_MAX)) return STATE_MAX;
      return longint'(mag[63:0]);
    endfunction

    function longint scale_int(logic signed [bqd_pkg::COEF_W-1:0] c, longint x);
      logic [127:0] p;
      p = 128'(mag_of(longint'(c))) * 128'(mag_of(x));
      return from_mag((c < 0) != (x < 0), p);
    endfunction

    // Fractional product: truncate the magnitude toward zero
    function longint scale_frac(logic signed [bqd_pkg::COEF_W-1:0] c, longint v);
      logic [127:0] p;
      p = (128'(mag_of(longint'(c))) * 128'(mag_of(v))) >> FRAC_W;
      return from_mag((c < 0) != (v < 0), p);
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > STATE_MAX) return STATE_MAX;
      if (s < STATE_MIN) return STATE_MIN;
      return s;
    endfunction

    function longint sat_neg(longint a);
      if (a == STATE_MIN) return STATE_MAX;
      return -a;
    endfunction

    // Drop the fraction toward zero and clamp to the sample range
    function logic signed [bqd_pkg::SAMPLE_W-1:0] to_sample(longint acc);
      logic [63:0] q;
      q = mag_of(acc) >> FRAC_W;
      if (acc < 0) begin
        if (q > 64'(bqd_pkg::OUT_NEG_LIM)) return bqd_pkg::OUT_MIN;
        return bqd_pkg::SAMPLE_W'(-longint'(q));
      end
      if (q > 64'(bqd_pkg::OUT_POS_LIM)) return bqd_pkg::OUT_MAX;
      return bqd_pkg::SAMPLE_W'(q);
    endfunction

    function void write_coef(bqd_pkg::coef_idx_t idx, logic [bqd_pkg::COEF_W-1:0] d);
      if (int'(idx) >= bqd_pkg::COEF_N) return;
      coef_q[idx] = d;
      delay_one   = 0;
      delay_two   = 0;
    endfunction

    // Advance the filter by one accepted item
    function void take_item(logic cmd, logic signed [bqd_pkg::SAMPLE_W-1:0] s);
      longint x;
      longint acc;
      longint nd1;
      longint nd2;
      if (cmd == bqd_pkg::CMD_CLEAR) begin
        delay_one = 0;
        delay_two = 0;
        return;
      end
      x   = longint'(s);
      acc = sat_add(scale_int(coef_q[bqd_pkg::COEF_B0], x), delay_one);
      nd1 = sat_add(sat_add(scale_int(coef_q[bqd_pkg::COEF_B1], x),
                            sat_neg(scale_frac(coef_q[bqd_pkg::COEF_A1], acc))),
                    delay_two);
      nd2 = sat_add(scale_int(coef_q[bqd_pkg::COEF_B2], x),
                    sat_neg(scale_frac(coef_q[bqd_pkg::COEF_A2], acc)));
      delay_one = nd1;
      delay_two = nd2;
      pending_out.push_back(to_sample(acc));
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic signed [bqd_pkg::SAMPLE_W-1:0] got);
      logic signed [bqd_pkg::SAMPLE_W-1:0] want;
      if (pending_out.size() == 0) begin
        report($sformatf("unexpected sample_out %0d", got));
        return;
      end
      want = pending_out.pop_front();
      if (got !== want)
        report($sformatf("sample_out mismatch: expected %0d, got %0d", want, got));
    endfunction
  endclass

  logic                                clk          = 1'b0;
  logic                                rst_n        = 1'b0;
  logic                                in_valid     = 1'b0;
  logic                                in_ready;
  logic                                in_cmd       = bqd_pkg::CMD_FILTER;
  logic signed [bqd_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                out_valid;
  logic                                out_ready    = 1'b0;
  logic signed [bqd_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                cfg_we       = 1'b0;
  bqd_pkg::coef_idx_t                  cfg_idx      = bqd_pkg::COEF_B0;
  logic        [bqd_pkg::COEF_W-1:0]   cfg_data     = '0;

  bit               calm         = 1'b0;
  int               quiet_cycles = 0;
  biquad_scoreboard sb;

  biquad_iir_df2t_filter_core #(
    .COEF_FRAC_BITS(FRAC_W),
    .STATE_WIDTH   (STATE_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Stall the output side now and then, except during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  // Track accepted items on both channels and count quiet cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.take_item(in_cmd, in_sample_in);
      if (out_valid && out_ready) sb.check_result(out_sample_out);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Give up when nothing moves for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  // Present one item, after an occasional gap, and hold it until accepted
  task automatic send_item(logic cmd, logic signed [bqd_pkg::SAMPLE_W-1:0] s);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid     <= 1'b0;
      in_cmd       <= 1'($urandom);
      in_sample_in <= bqd_pkg::SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Leave cfg_we high so back-to-back writes need no toggling
  task automatic write_coef(bqd_pkg::coef_idx_t idx, logic [bqd_pkg::COEF_W-1:0] d);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_coef(idx, d);
  endtask

  task automatic load_coefs(logic [bqd_pkg::COEF_W-1:0] b0, logic [bqd_pkg::COEF_W-1:0] b1,
                            logic [bqd_pkg::COEF_W-1:0] b2, logic [bqd_pkg::COEF_W-1:0] a1,
                            logic [bqd_pkg::COEF_W-1:0] a2);
    write_coef(bqd_pkg::COEF_B0, b0);
    write_coef(bqd_pkg::COEF_B1, b1);
    write_coef(bqd_pkg::COEF_B2, b2);
    write_coef(bqd_pkg::COEF_A1, a1);
    write_coef(bqd_pkg::COEF_A2, a2);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every due sample, then let a trailing clear finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [bqd_pkg::COEF_W-1:0] pick_coef(int i);
    case ($urandom_range(3))
      0: return bqd_pkg::COEF_RESET[i];
      1: return $urandom;
      2: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return 32'($signed($urandom) >>> 3);
    endcase
  endfunction

  initial begin
    int                                  ph;
    int                                  k;
    int                                  walk;
    int                                  mode;
    logic                                cmd;
    logic signed [bqd_pkg::SAMPLE_W-1:0] s;

    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset coefficients: field extremes, unit steps, clear mid-stream
    send_item(bqd_pkg::CMD_FILTER, 17'sd0);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MAX);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MAX);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MIN);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MIN);
    send_item(bqd_pkg::CMD_FILTER, 17'sd1);
    send_item(bqd_pkg::CMD_FILTER, -17'sd1);
    send_item(bqd_pkg::CMD_CLEAR, bqd_pkg::OUT_MAX);
    for (k = 0; k < 3; k++) send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MAX);
    settle();

    // Extreme coefficients: output clamp, state clamp, negated minimum
    load_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    for (k = 0; k < 5; k++) send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MAX);
    for (k = 0; k < 3; k++) send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MIN);
    settle();

    // Out-of-range index: no register changes and the delays survive
    write_coef(bqd_pkg::coef_idx_t'(bqd_pkg::COEF_N + $urandom_range(2)), $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_item(bqd_pkg::CMD_FILTER, 17'sd0);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MIN);
    send_item(bqd_pkg::CMD_CLEAR, bqd_pkg::OUT_MIN);
    send_item(bqd_pkg::CMD_FILTER, 17'sd0);
    send_item(bqd_pkg::CMD_FILTER, bqd_pkg::OUT_MAX);
    settle();

    // Random phases, each with its own coefficient set and sample style
    walk = 0;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm <= (ph == 3);
      for (k = 0; k < bqd_pkg::COEF_N; k++) begin
        if (ph == 0 || $urandom_range(99) < 70)
          write_coef(bqd_pkg::coef_idx_t'(k), pick_coef(k));
      end
      if ($urandom_range(3) == 0)
        write_coef(bqd_pkg::coef_idx_t'(bqd_pkg::COEF_N + $urandom_range(2)), $urandom);
      cfg_we <= 1'b0;
      @(posedge clk);
      mode = ph % 3;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        cmd = ($urandom_range(99) < 5) ? bqd_pkg::CMD_CLEAR : bqd_pkg::CMD_FILTER;
        case (mode)
          0: s = bqd_pkg::SAMPLE_W'($urandom);
          1: begin
            walk = walk + int'($urandom_range(2000)) - 1000;
            if (walk > bqd_pkg::OUT_POS_LIM) walk = bqd_pkg::OUT_POS_LIM;
            if (walk < -bqd_pkg::OUT_NEG_LIM) walk = -bqd_pkg::OUT_NEG_LIM;
            s = bqd_pkg::SAMPLE_W'(walk);
          end
          default: begin
            case ($urandom_range(3))
              0:       s = bqd_pkg::OUT_MAX;
              1:       s = bqd_pkg::OUT_MIN;
              default: s = bqd_pkg::SAMPLE_W'($urandom);
            endcase
          end
        endcase
        send_item(cmd, s);
      end
      settle();
    end

    calm <= 1'b0;
    settle();
    if (sb.errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/bqd_pkg.sv
rtl/bqd_seq.sv
rtl/bqd_dp.sv
rtl/biquad_iir_df2t_filter_core.sv
test/tb.sv
